// ===== hdl/tfwm_pkg.sv =====
// Package for the topic filter wildcard matcher.
// Holds the store sizes, character codes, state and verdict types, and the
// command and status structs that pass between the controller and the datapath.
package tfwm_pkg;

    localparam int MAX_FILTER_LEN = 64;
    localparam int ADDR_W         = $clog2(MAX_FILTER_LEN);
    localparam int LEN_W          = 7;
    localparam int CHAR_W         = 8;

    localparam logic [LEN_W-1:0] FILTER_LIMIT = LEN_W'(MAX_FILTER_LEN - 1);
    localparam logic [LEN_W-1:0] TOPIC_SAT    = {LEN_W{1'b1}};

    localparam logic [CHAR_W-1:0] CH_PLUS  = 8'h2B;
    localparam logic [CHAR_W-1:0] CH_HASH  = 8'h23;
    localparam logic [CHAR_W-1:0] CH_SLASH = 8'h2F;

    // Item kinds carried in the input tuser bit
    localparam logic ACT_FILTER = 1'b0;
    localparam logic ACT_TOPIC  = 1'b1;

    typedef enum logic [1:0] {
        V_RUN    = 2'd0,
        V_ACCEPT = 2'd1,
        V_REJECT = 2'd2
    } verdict_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_EVAL,
        ST_WAIT
    } state_t;

    typedef struct packed {
        logic accept_filter;
        logic accept_topic;
        logic advance;
        logic commit;
    } cmd_t;

    typedef struct packed {
        logic cont;
        logic last;
        logic out_busy;
    } status_t;

endpackage

// ===== hdl/tfwm_ctrl.sv =====
// Controller state machine for the topic filter matcher.
// Depends on tfwm_pkg; drives the datapath through cmd_t and reads status_t.
module tfwm_ctrl
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             s_tvalid,
    input  logic             s_tuser,
    output logic             s_tready,
    input  tfwm_pkg::status_t status,
    output tfwm_pkg::cmd_t   cmd
);

    tfwm_pkg::state_t state_reg;
    tfwm_pkg::state_t state_next;

    // Hold the state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= tfwm_pkg::ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // Choose the next state and issue commands
    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        s_tready   = 1'b0;
        unique case (state_reg)
            tfwm_pkg::ST_IDLE:
            begin
                s_tready = 1'b1;
                if (s_tvalid)
                begin
                    if (s_tuser == tfwm_pkg::ACT_TOPIC)
                    begin
                        cmd.accept_topic = 1'b1;
                        state_next       = tfwm_pkg::ST_EVAL;
                    end
                    else
                    begin
                        cmd.accept_filter = 1'b1;
                    end
                end
            end
            tfwm_pkg::ST_EVAL:
            begin
                if (status.cont)
                begin
                    cmd.advance = 1'b1;
                    state_next  = tfwm_pkg::ST_WAIT;
                end
                else if (!(status.last && status.out_busy))
                begin
                    cmd.commit = 1'b1;
                    state_next = tfwm_pkg::ST_IDLE;
                end
            end
            tfwm_pkg::ST_WAIT:
            begin
                // wait for the store read at the new filter position
                state_next = tfwm_pkg::ST_EVAL;
            end
            default:
            begin
                state_next = tfwm_pkg::ST_IDLE;
            end
        endcase
    end

endmodule

// ===== hdl/tfwm_dpath.sv =====
// Datapath for the topic filter matcher: filter store, matcher state and
// the result register. Depends on tfwm_pkg; driven by tfwm_ctrl commands.
module tfwm_dpath
(
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            cfg_we,
    input  logic                            cfg_wdata,
    input  logic [tfwm_pkg::CHAR_W-1:0]     s_tdata,
    input  logic                            s_tlast,
    input  tfwm_pkg::cmd_t                  cmd,
    output tfwm_pkg::status_t               status,
    output logic                            m_tvalid,
    input  logic                            m_tready,
    output logic                            matched
);

    logic [tfwm_pkg::CHAR_W-1:0] mem [tfwm_pkg::MAX_FILTER_LEN];
    logic [tfwm_pkg::CHAR_W-1:0] rd_lit_reg;
    logic [tfwm_pkg::CHAR_W-1:0] rd_wild_reg;
    logic [tfwm_pkg::CHAR_W-1:0] char_reg;
    logic                        last_reg;
    logic [tfwm_pkg::LEN_W-1:0]  len_reg;
    logic                        complete_reg;
    logic [tfwm_pkg::LEN_W-1:0]  fp_reg;
    logic [tfwm_pkg::LEN_W-1:0]  tp_reg;
    logic                        skip_reg;
    tfwm_pkg::verdict_t          verdict_reg;
    logic                        lit_reg;
    logic                        wen_reg;
    logic                        m_valid_reg;
    logic                        matched_reg;

    logic [tfwm_pkg::LEN_W-1:0]  len_base;
    logic                        store_we;
    logic [tfwm_pkg::LEN_W-1:0]  fp_next;
    logic [tfwm_pkg::LEN_W-1:0]  tp_next;
    logic                        skip_next;
    tfwm_pkg::verdict_t          verdict_next;
    logic                        lit_next;
    logic                        cont;
    logic                        slash;
    logic                        wild_ok;
    logic                        match_next;

    // Work out the write slot of a filter character
    always_comb
    begin
        len_base = complete_reg ? '0 : len_reg;
        store_we = cmd.accept_filter && (len_base < tfwm_pkg::FILTER_LIMIT);
    end

    // Filter store: one write port, two registered read ports
    always_ff @(posedge clk)
    begin
        if (store_we)
        begin
            mem[len_base[tfwm_pkg::ADDR_W-1:0]] <= s_tdata;
        end
        rd_lit_reg  <= mem[tp_reg[tfwm_pkg::ADDR_W-1:0]];
        rd_wild_reg <= mem[fp_reg[tfwm_pkg::ADDR_W-1:0]];
    end

    // One step of the wildcard matcher plus the literal compare
    always_comb
    begin
        slash        = (char_reg == tfwm_pkg::CH_SLASH);
        fp_next      = fp_reg;
        skip_next    = skip_reg;
        verdict_next = verdict_reg;
        cont         = 1'b0;
        if (verdict_reg == tfwm_pkg::V_RUN && !(skip_reg && !slash))
        begin
            skip_next = 1'b0;
            if (fp_reg >= len_reg)
            begin
                verdict_next = tfwm_pkg::V_REJECT;
            end
            else if (rd_wild_reg == tfwm_pkg::CH_HASH)
            begin
                verdict_next = tfwm_pkg::V_ACCEPT;
            end
            else if (rd_wild_reg == tfwm_pkg::CH_PLUS)
            begin
                fp_next = fp_reg + 1'b1;
                if (slash)
                begin
                    cont = 1'b1;
                end
                else
                begin
                    skip_next = 1'b1;
                end
            end
            else if (rd_wild_reg == char_reg)
            begin
                fp_next = fp_reg + 1'b1;
            end
            else
            begin
                verdict_next = tfwm_pkg::V_REJECT;
            end
        end
        lit_next   = lit_reg && (tp_reg < len_reg) && (rd_lit_reg == char_reg);
        tp_next    = (tp_reg == tfwm_pkg::TOPIC_SAT) ? tp_reg : tp_reg + 1'b1;
        wild_ok    = (verdict_next == tfwm_pkg::V_ACCEPT) ||
                     (verdict_next == tfwm_pkg::V_RUN && fp_next >= len_reg);
        match_next = (lit_next && tp_next == len_reg) || (wen_reg && wild_ok);
    end

    // Latch the topic character, and the match result on a final commit
    always_ff @(posedge clk)
    begin
        if (cmd.accept_topic)
        begin
            char_reg <= s_tdata;
            last_reg <= s_tlast;
        end
        if (cmd.commit && last_reg)
        begin
            matched_reg <= match_next;
        end
    end

    // Update filter and matcher state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            len_reg      <= '0;
            complete_reg <= 1'b1;
            fp_reg       <= '0;
            tp_reg       <= '0;
            skip_reg     <= 1'b0;
            verdict_reg  <= tfwm_pkg::V_RUN;
            lit_reg      <= 1'b1;
            wen_reg      <= 1'b0;
            m_valid_reg  <= 1'b0;
        end
        else
        begin
            if (cfg_we)
            begin
                wen_reg <= cfg_wdata;
            end
            // Raise the output on a verdict, drop it once taken
            if (cmd.commit && last_reg)
            begin
                m_valid_reg <= 1'b1;
            end
            else if (m_valid_reg && m_tready)
            begin
                m_valid_reg <= 1'b0;
            end
            if (cmd.accept_filter)
            begin
                len_reg      <= len_base + {{(tfwm_pkg::LEN_W-1){1'b0}}, store_we};
                complete_reg <= s_tlast;
                fp_reg       <= '0;
                tp_reg       <= '0;
                skip_reg     <= 1'b0;
                verdict_reg  <= tfwm_pkg::V_RUN;
                lit_reg      <= 1'b1;
            end
            if (cmd.accept_topic)
            begin
                complete_reg <= 1'b1;
            end
            if (cmd.advance)
            begin
                fp_reg   <= fp_next;
                skip_reg <= skip_next;
            end
            if (cmd.commit)
            begin
                if (last_reg)
                begin
                    // give the verdict and clear the matcher
                    fp_reg      <= '0;
                    tp_reg      <= '0;
                    skip_reg    <= 1'b0;
                    verdict_reg <= tfwm_pkg::V_RUN;
                    lit_reg     <= 1'b1;
                end
                else
                begin
                    fp_reg      <= fp_next;
                    tp_reg      <= tp_next;
                    skip_reg    <= skip_next;
                    verdict_reg <= verdict_next;
                    lit_reg     <= lit_next;
                end
            end
        end
    end

    assign status.cont     = cont;
    assign status.last     = last_reg;
    assign status.out_busy = m_valid_reg && !m_tready;
    assign m_tvalid        = m_valid_reg;
    assign matched         = matched_reg;

endmodule

// ===== hdl/topic_filter_wildcard_match_top.sv =====
// Top level of the topic filter wildcard matcher.
// Depends on tfwm_pkg, tfwm_ctrl and tfwm_dpath.
//
//  Channel   Direction  Contents
//  s_*       in         tdata = character, tuser = action, tlast = last
//  m_*       out        tdata[0] = matched, zero padded to a byte
//  cfg_*     in         wildcards_enabled, written when cfg_we is high
//
// A filter item is taken in the idle state. A topic item passes through the
// evaluate state, plus a wait state for each '+' in the filter that a '/'
// steps over, as the filter store has a registered read port.
// rst_n clears all control state; the filter store is not cleared.
// A final topic item waits before its verdict while the output register
// still holds an item not taken.
module topic_filter_wildcard_match_top
(
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            cfg_we,
    input  logic                            cfg_wdata,
    input  logic                            s_tvalid,
    output logic                            s_tready,
    input  logic [tfwm_pkg::CHAR_W-1:0]     s_tdata,   // [7:0] character
    input  logic                            s_tuser,   // [0] action
    input  logic                            s_tlast,
    output logic                            m_tvalid,
    input  logic                            m_tready,
    output logic [7:0]                      m_tdata    // [0] matched, [7:1] zero
);

    tfwm_pkg::cmd_t    cmd;
    tfwm_pkg::status_t status;
    logic              matched;

    tfwm_ctrl u_ctrl
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tuser  (s_tuser),
        .s_tready (s_tready),
        .status   (status),
        .cmd      (cmd)
    );

    tfwm_dpath u_dpath
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata),
        .s_tdata   (s_tdata),
        .s_tlast   (s_tlast),
        .cmd       (cmd),
        .status    (status),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .matched   (matched)
    );

    assign m_tdata = {7'b0, matched};

endmodule

// ===== tb/sv/topic_filter_wildcard_match_top_tb.sv =====
`timescale 1ns / 100ps
// Self-checking testbench for topic_filter_wildcard_match_top.
// Depends on tfwm_pkg and the matcher RTL; predicts every verdict in-line
// and checks each output item against the oldest pending prediction.
module topic_filter_wildcard_match_top_tb;

    localparam int    CLK_HALF_NS  = 6;
    localparam int    RESET_CYCLES = 12;
    localparam int    SETTLE_CYCLES = 160;   // '/' over 63 '+' is the slowest step
    localparam longint RUN_LIMIT_NS = 64'd10_000_000;
    localparam int    RANDOM_ITEMS = 160;
    localparam int    RANDOM_PHASES = 4;

    typedef enum int { RX_OPEN, RX_COIN, RX_SPARSE, RX_BEAT } rx_mode_t;

    logic                        clk;
    logic                        rst_n;
    logic                        cfg_we;
    logic                        cfg_wdata;
    logic                        s_tvalid;
    logic                        s_tready;
    logic [tfwm_pkg::CHAR_W-1:0] s_tdata;    // [7:0] character
    logic                        s_tuser;    // [0] action
    logic                        s_tlast;
    logic                        m_tvalid;
    logic                        m_tready;
    logic [7:0]                  m_tdata;    // [0] matched, [7:1] zero

    // Shadow of the matcher state
    logic [tfwm_pkg::CHAR_W-1:0] flt_store [tfwm_pkg::MAX_FILTER_LEN];
    logic [tfwm_pkg::LEN_W-1:0]  flt_len;
    bit                          flt_closed;
    logic [tfwm_pkg::LEN_W-1:0]  flt_pos;
    logic [tfwm_pkg::LEN_W-1:0]  tpc_pos;
    bit                          skip_lvl;
    tfwm_pkg::verdict_t          verd;
    bit                          lit_eq;
    bit                          wild_en;

    bit                matched_q [$];
    bit                exp_matched;
    logic [7:0]        seq_buf [$];
    logic [7:0]        flt_text [$];

    int errors;
    int n_items;
    int n_verdicts;
    int n_accepts;
    int burst_left;

    topic_filter_wildcard_match_top dut
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .s_tlast   (s_tlast),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata)
    );

    initial
    begin
        clk = 1'b0;
        forever #CLK_HALF_NS clk = ~clk;
    end

    // ------------------------------------------------------------------
    // Verdict predictor
    // ------------------------------------------------------------------

    function automatic void restart_match();
        flt_pos  = '0;
        tpc_pos  = '0;
        skip_lvl = 1'b0;
        verd     = tfwm_pkg::V_RUN;
        lit_eq   = 1'b1;
    endfunction

    // Step the wildcard walk by one topic character; '/' may pass several '+'
    function automatic void walk_wildcards(input logic [7:0] c);
        logic [7:0] s;
        bit         done;
        done = 1'b0;
        while (!done)
        begin
            if (skip_lvl && c != tfwm_pkg::CH_SLASH)
                done = 1'b1;
            else
            begin
                skip_lvl = 1'b0;
                if (flt_pos >= flt_len)
                begin
                    verd = tfwm_pkg::V_REJECT;
                    done = 1'b1;
                end
                else
                begin
                    s = flt_store[flt_pos[tfwm_pkg::ADDR_W-1:0]];
                    if (s == tfwm_pkg::CH_HASH)
                    begin
                        verd = tfwm_pkg::V_ACCEPT;
                        done = 1'b1;
                    end
                    else if (s == tfwm_pkg::CH_PLUS)
                    begin
                        flt_pos = flt_pos + 1'b1;
                        if (c != tfwm_pkg::CH_SLASH)
                        begin
                            skip_lvl = 1'b1;
                            done     = 1'b1;
                        end
                    end
                    else if (s == c)
                    begin
                        flt_pos = flt_pos + 1'b1;
                        done    = 1'b1;
                    end
                    else
                    begin
                        verd = tfwm_pkg::V_REJECT;
                        done = 1'b1;
                    end
                end
            end
        end
    endfunction

    // Apply one accepted item; queue a verdict when a topic ends
    function automatic void predict_match(input logic act, input logic [7:0] c,
                                          input logic last);
        bit lit;
        bit wild;
        if (act == tfwm_pkg::ACT_FILTER)
        begin
            if (flt_closed)
            begin
                flt_len    = '0;
                flt_closed = 1'b0;
            end
            if (flt_len < tfwm_pkg::FILTER_LIMIT)
            begin
                flt_store[flt_len[tfwm_pkg::ADDR_W-1:0]] = c;
                flt_len = flt_len + 1'b1;
            end
            if (last)
                flt_closed = 1'b1;
            restart_match();
        end
        else
        begin
            flt_closed = 1'b1;
            if (tpc_pos >= flt_len || flt_store[tpc_pos[tfwm_pkg::ADDR_W-1:0]] != c)
                lit_eq = 1'b0;
            if (verd == tfwm_pkg::V_RUN)
                walk_wildcards(c);
            if (tpc_pos < tfwm_pkg::TOPIC_SAT)
                tpc_pos = tpc_pos + 1'b1;
            if (last)
            begin
                lit = lit_eq && (tpc_pos == flt_len);
                if (verd == tfwm_pkg::V_ACCEPT)
                    wild = 1'b1;
                else if (verd == tfwm_pkg::V_REJECT)
                    wild = 1'b0;
                else
                    wild = (flt_pos >= flt_len);
                matched_q = {matched_q, lit || (wild_en && wild)};
                restart_match();
            end
        end
    endfunction

    // ------------------------------------------------------------------
    // Item driver and register write
    // ------------------------------------------------------------------

    // Offer one item in bursts with random gaps; returns at the falling edge
    task automatic send_item(input logic act, input logic [7:0] c, input logic last);
        if (burst_left <= 0)
        begin
            repeat ($urandom_range(0, 6)) @(negedge clk);
            burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(30, 60)
                                                     : $urandom_range(1, 12);
        end
        s_tvalid = 1'b1;
        s_tuser  = act;
        s_tdata  = c;
        s_tlast  = last;
        @(posedge clk);
        while (!s_tready)
            @(posedge clk);
        predict_match(act, c, last);
        n_items++;
        burst_left--;
        @(negedge clk);
        s_tvalid = 1'b0;
    endtask

    // Send seq_buf as one run, marking the final item when asked
    task automatic send_seq(input logic act, input bit close);
        for (int i = 0; i < seq_buf.size(); i++)
            send_item(act, seq_buf[i], close && (i == seq_buf.size() - 1));
    endtask

    function automatic void load_text(input string s);
        seq_buf.delete();
        for (int i = 0; i < s.len(); i++)
            seq_buf = {seq_buf, s[i]};
    endfunction

    // Drain, let the core settle, then write the register
    task automatic write_wildcards(input bit en);
        while (matched_q.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(negedge clk);
        cfg_we    = 1'b1;
        cfg_wdata = en;
        @(negedge clk);
        cfg_we    = 1'b0;
        wild_en   = en;
    endtask

    // ------------------------------------------------------------------
    // Random content
    // ------------------------------------------------------------------

    function automatic logic [7:0] pick_char(input string alphabet);
        if ($urandom_range(0, 15) == 0)
            return 8'($urandom_range(1, 255));
        return alphabet[$urandom_range(0, alphabet.len() - 1)];
    endfunction

    // Build a filter in flt_text: levels of text, '+' and an optional '#'
    function automatic void make_filter();
        int nlev;
        int len;
        flt_text.delete();
        case ($urandom_range(0, 9))
            0:
            begin
                len = $urandom_range(40, 70);
                repeat (len) flt_text = {flt_text, pick_char("ab/+")};
            end
            1, 2:
            begin
                len = $urandom_range(1, 8);
                repeat (len) flt_text = {flt_text, pick_char("ab/+#")};
            end
            default:
            begin
                nlev = $urandom_range(1, 4);
                for (int l = 0; l < nlev; l++)
                begin
                    if (l > 0)
                        flt_text = {flt_text, tfwm_pkg::CH_SLASH};
                    if (l == nlev - 1 && $urandom_range(0, 3) == 0)
                        flt_text = {flt_text, tfwm_pkg::CH_HASH};
                    else if ($urandom_range(0, 3) == 0)
                        flt_text = {flt_text, tfwm_pkg::CH_PLUS};
                    else
                        repeat ($urandom_range(1, 3)) flt_text = {flt_text, pick_char("ab")};
                end
            end
        endcase
    endfunction

    // Build a topic in seq_buf that the filter should mostly accept
    function automatic void make_topic();
        int pos;
        seq_buf.delete();
        foreach (flt_text[i])
        begin
            if (flt_text[i] == tfwm_pkg::CH_HASH)
            begin
                repeat ($urandom_range(0, 4)) seq_buf = {seq_buf, pick_char("ab/")};
                break;
            end
            else if (flt_text[i] == tfwm_pkg::CH_PLUS)
                repeat ($urandom_range(0, 2)) seq_buf = {seq_buf, pick_char("ab")};
            else
                seq_buf = {seq_buf, flt_text[i]};
        end
        if (seq_buf.size() == 0)
            seq_buf = {seq_buf, 8'("a")};
        // Spoil some topics to exercise rejection
        case ($urandom_range(0, 5))
            0:
            begin
                pos = $urandom_range(0, seq_buf.size() - 1);
                seq_buf[pos] = pick_char("ab/+#");
            end
            1: seq_buf = {seq_buf, pick_char("ab/")};
            default: ;
        endcase
    endfunction

    // ------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------

    // No filter loaded yet, wildcards off from reset
    task automatic test_empty_filter();
        load_text("a");
        send_seq(tfwm_pkg::ACT_TOPIC, 1'b1);
    endtask

    task automatic test_directed();
        // '+' spans one level
        load_text("a/+/c");
        send_seq(tfwm_pkg::ACT_FILTER, 1'b1);
        load_text("a/x/c");
        send_seq(tfwm_pkg::ACT_TOPIC, 1'b1);
        // '#' takes everything, with the character extremes
        load_text("#");
        send_seq(tfwm_pkg::ACT_FILTER, 1'b1);
        seq_buf = '{8'hFF, 8'h01};
        send_seq(tfwm_pkg::ACT_TOPIC, 1'b1);
        // '#' only reached after the topic has ended
        load_text("a/#");
        send_seq(tfwm_pkg::ACT_FILTER, 1'b1);
        load_text("a");
        send_seq(tfwm_pkg::ACT_TOPIC, 1'b1);
        // topic closes a filter still being loaded
        load_text("ab");
        send_seq(tfwm_pkg::ACT_FILTER, 1'b0);
        send_seq(tfwm_pkg::ACT_TOPIC, 1'b1);
        // filter item abandons a topic in flight
        send_item(tfwm_pkg::ACT_TOPIC, "x", 1'b0);
        send_item(tfwm_pkg::ACT_FILTER, "z", 1'b1);
        send_item(tfwm_pkg::ACT_TOPIC, "z", 1'b1);
    endtask

    // Topics longer than the position counter can hold
    task automatic test_long_topic();
        load_text("a/#");
        send_seq(tfwm_pkg::ACT_FILTER, 1'b1);
        seq_buf = '{"a", tfwm_pkg::CH_SLASH};
        repeat (128) seq_buf = {seq_buf, 8'("b")};
        send_seq(tfwm_pkg::ACT_TOPIC, 1'b1);
        load_text("a");
        send_seq(tfwm_pkg::ACT_FILTER, 1'b1);
        seq_buf.delete();
        repeat (130) seq_buf = {seq_buf, 8'("a")};
        send_seq(tfwm_pkg::ACT_TOPIC, 1'b1);
    endtask

    // Filter longer than the store: truncated to its first 63 characters
    task automatic test_filter_overflow();
        seq_buf.delete();
        for (int i = 0; i < 70; i++)
            seq_buf = {seq_buf, 8'h40 + 8'(i % 26)};
        send_seq(tfwm_pkg::ACT_FILTER, 1'b1);
        seq_buf = seq_buf[0:62];
        send_seq(tfwm_pkg::ACT_TOPIC, 1'b1);
        seq_buf = {seq_buf, 8'h40};
        send_seq(tfwm_pkg::ACT_TOPIC, 1'b1);
    endtask

    // Mostly filter-then-topics sequences, with broken runs and noise
    task automatic test_random(input int target);
        int stop_at;
        stop_at = n_items + target;
        while (n_items < stop_at)
        begin
            case ($urandom_range(0, 9))
                7:
                begin
                    // topic arrives while the filter is still open
                    make_filter();
                    seq_buf = flt_text;
                    send_seq(tfwm_pkg::ACT_FILTER, 1'b0);
                    make_topic();
                    send_seq(tfwm_pkg::ACT_TOPIC, 1'b1);
                end
                8:
                begin
                    // topic left unfinished
                    make_topic();
                    send_seq(tfwm_pkg::ACT_TOPIC, 1'b0);
                end
                9:
                begin
                    repeat ($urandom_range(1, 6))
                        send_item($urandom_range(0, 1) ? tfwm_pkg::ACT_TOPIC
                                                       : tfwm_pkg::ACT_FILTER,
                                  8'($urandom_range(1, 255)), 1'($urandom_range(0, 1)));
                end
                default:
                begin
                    make_filter();
                    seq_buf = flt_text;
                    send_seq(tfwm_pkg::ACT_FILTER, 1'b1);
                    repeat ($urandom_range(1, 4))
                    begin
                        make_topic();
                        send_seq(tfwm_pkg::ACT_TOPIC, 1'b1);
                    end
                end
            endcase
        end
    endtask

    // ------------------------------------------------------------------
    // Output side: stall pattern and verdict check
    // ------------------------------------------------------------------

    initial
    begin : receiver
        rx_mode_t mode;
        int       left;
        int       beat;
        m_tready = 1'b1;
        mode     = RX_OPEN;
        left     = 0;
        beat     = 0;
        forever
        begin
            @(negedge clk);
            if (left == 0)
            begin
                mode = rx_mode_t'($urandom_range(0, 3));
                left = $urandom_range(16, 80);
            end
            left--;
            beat++;
            case (mode)
                RX_OPEN:   m_tready = 1'b1;
                RX_COIN:   m_tready = 1'($urandom_range(0, 1));
                RX_SPARSE: m_tready = ($urandom_range(0, 3) == 0);
                default:   m_tready = ((beat % 8) < 4);
            endcase
        end
    end

    always @(posedge clk)
    begin
        if (rst_n && m_tvalid && m_tready)
        begin
            if (matched_q.size() == 0)
            begin
                $error("verdict item with none pending: m_tdata=%h", m_tdata);
                errors++;
            end
            else
            begin
                exp_matched = matched_q.pop_front();
                n_verdicts++;
                if (exp_matched)
                    n_accepts++;
                if (m_tdata[0] !== exp_matched)
                begin
                    $error("matched: expected %0b, got %0b", exp_matched, m_tdata[0]);
                    errors++;
                end
                if (m_tdata[7:1] !== 7'd0)
                begin
                    $error("padding: expected 00, got %h", m_tdata[7:1]);
                    errors++;
                end
            end
        end
    end

    // ------------------------------------------------------------------
    // Sequence
    // ------------------------------------------------------------------

    initial
    begin
        rst_n      = 1'b0;
        cfg_we     = 1'b0;
        cfg_wdata  = 1'b0;
        s_tvalid   = 1'b0;
        s_tdata    = '0;
        s_tuser    = tfwm_pkg::ACT_FILTER;
        s_tlast    = 1'b0;
        errors     = 0;
        n_items    = 0;
        n_verdicts = 0;
        n_accepts  = 0;
        burst_left = 0;
        flt_len    = '0;
        flt_closed = 1'b1;
        wild_en    = 1'b0;
        restart_match();

        repeat (RESET_CYCLES) @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        test_empty_filter();
        write_wildcards(1'b1);
        test_directed();
        test_long_topic();
        write_wildcards(1'b0);
        test_filter_overflow();
        for (int p = 0; p < RANDOM_PHASES; p++)
        begin
            write_wildcards(p % 2 == 0);
            test_random(RANDOM_ITEMS / RANDOM_PHASES);
        end

        // Drain, then allow the slowest step to finish
        while (matched_q.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);

        $display("Sent %0d items (filter loads, topics, truncation, long topics, noise),",
                 n_items);
        $display("checked %0d verdicts, %0d accepted, with wildcards on and off.",
                 n_verdicts, n_accepts);
        if (errors == 0)
            $display("topic_filter_wildcard_match_top: match");
        else
            $display("topic_filter_wildcard_match_top: mismatch");
        $finish;
    end

    // Guard against a hung handshake
    initial
    begin
        #(RUN_LIMIT_NS);
        $display("Run limit reached with %0d verdicts pending", matched_q.size());
        $display("topic_filter_wildcard_match_top: mismatch");
        $finish;
    end

endmodule
